// ===== rtl/slfu_pkg.sv =====
package slfu_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int TYPE_W  = 2;
  localparam int KEY_W   = 32;
  localparam int LEN_W   = 20;
  localparam int BYTES_W = 17;
  localparam int USES_W  = 32;
  localparam int SLOT_W  = 5;

  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
  localparam logic [USES_W-1:0]  USES_MAX  = '1;
  localparam logic [BYTES_W-1:0] CAP_RESET = BYTES_W'(65536);

  localparam logic [TYPE_W-1:0] REQ_STORE  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_INVAL  = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_NONE   = 2'd3;

  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_EVICT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_FIND_DONE,
    ST_CHECK,
    ST_EVICT,
    ST_EVICT_DONE,
    ST_OUT
  } state_t;

  function automatic logic [BYTES_W-1:0] credit(input logic [BYTES_W-1:0] avail,
                                                input logic [BYTES_W-1:0] n);
    logic [BYTES_W:0] sum;
    sum = {1'b0, avail} + {1'b0, n};
    return sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
  endfunction

  function automatic logic [BYTES_W-1:0] debit(input logic [BYTES_W-1:0] avail,
                                               input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] wide;
    wide = LEN_W'(avail);
    return (wide >= n) ? BYTES_W'(wide - n) : '0;
  endfunction

endpackage

// ===== rtl/slfu_if.sv =====
interface slfu_req_if;
  logic                        valid;
  logic                        ready;
  logic [slfu_pkg::TYPE_W-1:0] req_type;
  logic [slfu_pkg::KEY_W-1:0]  obj_key;
  logic [slfu_pkg::LEN_W-1:0]  obj_length;

  modport source (output valid, req_type, obj_key, obj_length, input ready);
  modport sink   (input valid, req_type, obj_key, obj_length, output ready);
endinterface

interface slfu_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         item_kind;
  logic                         hit;
  logic [slfu_pkg::SLOT_W-1:0]  slot_index;
  logic [slfu_pkg::KEY_W-1:0]   evicted_key;
  logic [slfu_pkg::BYTES_W-1:0] free_bytes;
  logic                         last;

  modport source (output valid, item_kind, hit, slot_index, evicted_key, free_bytes, last,
                  input ready);
  modport sink   (input valid, item_kind, hit, slot_index, evicted_key, free_bytes, last,
                  output ready);
endinterface

interface slfu_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [slfu_pkg::BYTES_W-1:0] capacity_bytes;

  modport source (output valid, capacity_bytes, input ready);
  modport sink   (input valid, capacity_bytes, output ready);
endinterface

// ===== rtl/size_aware_lfu_cache_policy.sv =====
// Size-aware LFU replacement policy for a byte-budgeted cache of ENTRIES slots.
// req: one request per transaction (store, lookup, invalidate); taken only when idle.
// rsp: zero or more eviction reports (item_kind 1, last 0) then one completion
//   (item_kind 0, last 1); free_bytes is the budget left after each result.
// cfg: capacity write; clears every slot and resets free_bytes to the new value.
//   Taken while idle, ahead of a request offered in the same cycle.
// A lookup, invalidate or fitting store scans the slot memories one entry per cycle
// through a single registered read port and one key comparator: a lookup or
// invalidate then shows its completion, a plain store first passes a check step.
// Each eviction adds another scan with one shared use-count comparator; once its
// report is taken, the check step runs again and starts a further scan or shows
// the completion.
// An oversized store or an unused request type skips every scan.
// One request is in flight at a time; the next can be taken the cycle after its
// completion transaction, unless a cfg write is offered in that cycle.
// When rsp is stalled the result register holds and the sequencer waits.
// Reset empties all slots, sets capacity and free_bytes to 65536 and drops any
// pending result; no clearing pass is needed.
module size_aware_lfu_cache_policy (
  input  logic        clk,
  input  logic        rst,
  slfu_req_if.sink    req,
  slfu_rsp_if.source  rsp,
  slfu_cfg_if.sink    cfg
);

  slfu_pkg::state_t state, state_next;

  logic [slfu_pkg::BYTES_W-1:0] capacity;
  logic [slfu_pkg::BYTES_W-1:0] free_cnt;
  logic [slfu_pkg::ENTRIES-1:0] valid;

  logic [slfu_pkg::KEY_W-1:0]   key_mem  [slfu_pkg::ENTRIES];
  logic [slfu_pkg::BYTES_W-1:0] len_mem  [slfu_pkg::ENTRIES];
  logic [slfu_pkg::USES_W-1:0]  uses_mem [slfu_pkg::ENTRIES];

  logic [slfu_pkg::TYPE_W-1:0]  cur_type;
  logic [slfu_pkg::KEY_W-1:0]   cur_key;
  logic [slfu_pkg::LEN_W-1:0]   cur_len;

  logic [slfu_pkg::CNT_W-1:0]   cnt;
  logic                         rd_vld;
  logic [slfu_pkg::IDX_W-1:0]   rd_idx;
  logic [slfu_pkg::KEY_W-1:0]   rd_key;
  logic [slfu_pkg::BYTES_W-1:0] rd_len;
  logic [slfu_pkg::USES_W-1:0]  rd_uses;

  logic                         found;
  logic [slfu_pkg::IDX_W-1:0]   found_idx;
  logic [slfu_pkg::BYTES_W-1:0] found_len;
  logic [slfu_pkg::USES_W-1:0]  found_uses;

  logic                         best_vld;
  logic [slfu_pkg::IDX_W-1:0]   best_idx;
  logic [slfu_pkg::KEY_W-1:0]   best_key;
  logic [slfu_pkg::BYTES_W-1:0] best_len;
  logic [slfu_pkg::USES_W-1:0]  best_uses;

  logic                         o_kind;
  logic                         o_hit;
  logic [slfu_pkg::SLOT_W-1:0]  o_slot;
  logic [slfu_pkg::KEY_W-1:0]   o_key;
  logic [slfu_pkg::BYTES_W-1:0] o_free;
  logic                         o_last;

  logic                         in_acc, cfg_acc, rsp_acc;
  logic                         scanning, scan_issue, scan_end;
  logic [slfu_pkg::IDX_W-1:0]   rd_addr;
  logic [slfu_pkg::IDX_W-1:0]   free_slot;
  logic                         any_free, any_valid, need_evict, oversized;
  logic [slfu_pkg::BYTES_W-1:0] find_credit, best_credit, store_debit;

  logic                         new_we;
  logic                         uses_we;
  logic [slfu_pkg::IDX_W-1:0]   uses_waddr;
  logic [slfu_pkg::USES_W-1:0]  uses_wdata;

  assign cfg.ready = (state == slfu_pkg::ST_IDLE);
  assign req.ready = (state == slfu_pkg::ST_IDLE) && !cfg.valid;
  assign in_acc    = req.valid && req.ready;
  assign cfg_acc   = cfg.valid && cfg.ready;
  assign rsp_acc   = rsp.valid && rsp.ready;

  assign rsp.valid       = (state == slfu_pkg::ST_OUT);
  assign rsp.item_kind   = o_kind;
  assign rsp.hit         = o_hit;
  assign rsp.slot_index  = o_slot;
  assign rsp.evicted_key = o_key;
  assign rsp.free_bytes  = o_free;
  assign rsp.last        = o_last;

  assign scanning   = (state == slfu_pkg::ST_FIND) || (state == slfu_pkg::ST_EVICT);
  assign scan_issue = scanning && (cnt < slfu_pkg::CNT_W'(slfu_pkg::ENTRIES));
  assign scan_end   = scanning && (cnt == slfu_pkg::CNT_W'(slfu_pkg::ENTRIES)) && !rd_vld;
  assign rd_addr    = cnt[slfu_pkg::IDX_W-1:0];

  always_comb begin
    free_slot = '0;
    for (int i = slfu_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = slfu_pkg::IDX_W'(i);
      end
    end
  end

  assign any_free    = !(&valid);
  assign any_valid   = |valid;
  assign need_evict  = (slfu_pkg::LEN_W'(free_cnt) < cur_len) || !any_free;
  assign oversized   = (req.obj_length > slfu_pkg::LEN_W'(capacity));
  assign find_credit = slfu_pkg::credit(free_cnt, found_len);
  assign best_credit = slfu_pkg::credit(free_cnt, best_len);
  assign store_debit = slfu_pkg::debit(free_cnt, cur_len);

  assign new_we = (state == slfu_pkg::ST_CHECK) && !(need_evict && any_valid) && any_free;

  always_comb begin
    uses_we    = 1'b0;
    uses_waddr = found_idx;
    uses_wdata = (found_uses == slfu_pkg::USES_MAX) ? found_uses : found_uses + 1'b1;
    if (new_we) begin
      uses_we    = 1'b1;
      uses_waddr = free_slot;
      uses_wdata = slfu_pkg::USES_W'(1);
    end else if ((state == slfu_pkg::ST_FIND_DONE) && found &&
                 (cur_type == slfu_pkg::REQ_LOOKUP)) begin
      uses_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= rd_addr;
    rd_key  <= key_mem[rd_addr];
    rd_len  <= len_mem[rd_addr];
    rd_uses <= uses_mem[rd_addr];
    if (new_we) begin
      key_mem[free_slot] <= cur_key;
      len_mem[free_slot] <= cur_len[slfu_pkg::BYTES_W-1:0];
    end
    if (uses_we) begin
      uses_mem[uses_waddr] <= uses_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slfu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      slfu_pkg::ST_IDLE: begin
        if (in_acc) begin
          if ((req.req_type == slfu_pkg::REQ_STORE && oversized) ||
              req.req_type == slfu_pkg::REQ_NONE) begin
            state_next = slfu_pkg::ST_OUT;
          end else begin
            state_next = slfu_pkg::ST_FIND;
          end
        end
      end
      slfu_pkg::ST_FIND: begin
        if (scan_end) begin
          state_next = slfu_pkg::ST_FIND_DONE;
        end
      end
      slfu_pkg::ST_FIND_DONE: begin
        state_next = (cur_type == slfu_pkg::REQ_STORE) ? slfu_pkg::ST_CHECK : slfu_pkg::ST_OUT;
      end
      slfu_pkg::ST_CHECK: begin
        state_next = (need_evict && any_valid) ? slfu_pkg::ST_EVICT : slfu_pkg::ST_OUT;
      end
      slfu_pkg::ST_EVICT: begin
        if (scan_end) begin
          state_next = slfu_pkg::ST_EVICT_DONE;
        end
      end
      slfu_pkg::ST_EVICT_DONE: begin
        state_next = slfu_pkg::ST_OUT;
      end
      slfu_pkg::ST_OUT: begin
        if (rsp_acc) begin
          state_next = o_last ? slfu_pkg::ST_IDLE : slfu_pkg::ST_CHECK;
        end
      end
      default: begin
        state_next = slfu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= slfu_pkg::CAP_RESET;
      free_cnt <= slfu_pkg::CAP_RESET;
      valid    <= '0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= scan_issue;
      if (scan_issue) begin
        cnt <= cnt + 1'b1;
      end
      if (cfg_acc) begin
        capacity <= cfg.capacity_bytes;
        free_cnt <= cfg.capacity_bytes;
        valid    <= '0;
      end
      case (state)
        slfu_pkg::ST_IDLE: begin
          if (in_acc) begin
            cur_type <= req.req_type;
            cur_key  <= req.obj_key;
            cur_len  <= req.obj_length;
            cnt      <= '0;
            found    <= 1'b0;
            o_kind   <= slfu_pkg::KIND_DONE;
            o_hit    <= 1'b0;
            o_slot   <= '0;
            o_key    <= '0;
            o_last   <= 1'b1;
            if (req.req_type == slfu_pkg::REQ_STORE && oversized) begin
              valid    <= '0;
              free_cnt <= capacity;
              o_free   <= capacity;
            end else begin
              o_free <= free_cnt;
            end
          end
        end
        slfu_pkg::ST_FIND: begin
          if (rd_vld && !found && valid[rd_idx] && rd_key == cur_key) begin
            found      <= 1'b1;
            found_idx  <= rd_idx;
            found_len  <= rd_len;
            found_uses <= rd_uses;
          end
        end
        slfu_pkg::ST_FIND_DONE: begin
          if (found) begin
            if (cur_type == slfu_pkg::REQ_LOOKUP) begin
              o_hit  <= 1'b1;
              o_slot <= slfu_pkg::SLOT_W'(found_idx);
            end else begin
              valid[found_idx] <= 1'b0;
              free_cnt         <= find_credit;
              o_free           <= find_credit;
              if (cur_type == slfu_pkg::REQ_INVAL) begin
                o_hit  <= 1'b1;
                o_slot <= slfu_pkg::SLOT_W'(found_idx);
              end
            end
          end
        end
        slfu_pkg::ST_CHECK: begin
          o_kind <= slfu_pkg::KIND_DONE;
          o_key  <= '0;
          o_last <= 1'b1;
          if (need_evict && any_valid) begin
            cnt      <= '0;
            best_vld <= 1'b0;
          end else if (any_free) begin
            valid[free_slot] <= 1'b1;
            free_cnt         <= store_debit;
            o_hit            <= 1'b1;
            o_slot           <= slfu_pkg::SLOT_W'(free_slot);
            o_free           <= store_debit;
          end else begin
            o_hit  <= 1'b0;
            o_slot <= '0;
            o_free <= free_cnt;
          end
        end
        slfu_pkg::ST_EVICT: begin
          if (rd_vld && valid[rd_idx] && (!best_vld || rd_uses < best_uses)) begin
            best_vld  <= 1'b1;
            best_idx  <= rd_idx;
            best_key  <= rd_key;
            best_len  <= rd_len;
            best_uses <= rd_uses;
          end
        end
        slfu_pkg::ST_EVICT_DONE: begin
          valid[best_idx] <= 1'b0;
          free_cnt        <= best_credit;
          o_kind          <= slfu_pkg::KIND_EVICT;
          o_hit           <= 1'b0;
          o_slot          <= slfu_pkg::SLOT_W'(best_idx);
          o_key           <= best_key;
          o_free          <= best_credit;
          o_last          <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request taken while a result is pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    rsp_acc && rsp.last |=> state == slfu_pkg::ST_IDLE)
    else $error("sequencer not idle after completion");

  a_evict_report: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.item_kind |-> !rsp.last && !rsp.hit && !valid[best_idx])
    else $error("eviction report inconsistent with slot state");

  a_evict_found: assert property (@(posedge clk) disable iff (rst)
    state == slfu_pkg::ST_EVICT_DONE |-> best_vld && valid[best_idx])
    else $error("eviction scan found no victim");

endmodule

// ===== tb/tb_size_aware_lfu_cache_policy.sv =====
module tb_size_aware_lfu_cache_policy;
  import slfu_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
  localparam int RANDOM_ITEMS = 260;

  typedef struct packed {
    logic               is_cap;
    logic [TYPE_W-1:0]  req_type;
    logic [KEY_W-1:0]   obj_key;
    logic [LEN_W-1:0]   obj_length;
    logic [BYTES_W-1:0] capacity;
  } cache_op_t;

  typedef struct packed {
    logic               item_kind;
    logic               hit;
    logic [SLOT_W-1:0]  slot_index;
    logic [KEY_W-1:0]   evicted_key;
    logic [BYTES_W-1:0] free_bytes;
    logic               last;
  } cache_rsp_t;

  logic clk = 1'b0;
  logic rst;

  slfu_req_if req_bus ();
  slfu_rsp_if rsp_bus ();
  slfu_cfg_if cfg_bus ();

  size_aware_lfu_cache_policy dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cache_op_t  op_fifo[$];
  cache_rsp_t due_rsp[$];

  logic               cached   [ENTRIES];
  logic [KEY_W-1:0]   tag      [ENTRIES];
  logic [BYTES_W-1:0] held_len [ENTRIES];
  logic [USES_W-1:0]  uses     [ENTRIES];
  logic [BYTES_W-1:0] avail;
  logic [BYTES_W-1:0] budget;

  int req_total  = 0;
  int sent_cnt   = 0;
  int done_cnt   = 0;
  int mismatches = 0;
  int cycles     = 0;

  function automatic void post(logic kind, logic hit, int slot, logic [KEY_W-1:0] key,
                               logic last);
    cache_rsp_t r;
    r.item_kind   = kind;
    r.hit         = hit;
    r.slot_index  = SLOT_W'(slot);
    r.evicted_key = key;
    r.free_bytes  = avail;
    r.last        = last;
    due_rsp.push_back(r);
  endfunction

  function automatic void give_back(logic [BYTES_W-1:0] n);
    logic [BYTES_W:0] sum;
    sum = {1'b0, avail} + {1'b0, n};
    avail = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
  endfunction

  function automatic int find_slot(logic [KEY_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (cached[i] && tag[i] == key) return i;
    return -1;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < ENTRIES; i++)
      if (!cached[i]) return i;
    return -1;
  endfunction

  function automatic int least_used();
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (cached[i] && (best < 0 || uses[i] < uses[best])) best = i;
    return best;
  endfunction

  function automatic void set_capacity(logic [BYTES_W-1:0] value);
    budget = value;
    avail  = value;
    for (int i = 0; i < ENTRIES; i++) cached[i] = 1'b0;
  endfunction

  function automatic void lfu_apply(cache_op_t op);
    int s;
    int v;
    case (op.req_type)
      REQ_STORE: begin
        if (op.obj_length > LEN_W'(budget)) begin
          set_capacity(budget);
          post(KIND_DONE, 1'b0, 0, '0, 1'b1);
        end else begin
          s = find_slot(op.obj_key);
          if (s >= 0) begin
            cached[s] = 1'b0;
            give_back(held_len[s]);
          end
          while (LEN_W'(avail) < op.obj_length || first_free() < 0) begin
            v = least_used();
            if (v < 0) break;
            cached[v] = 1'b0;
            give_back(held_len[v]);
            post(KIND_EVICT, 1'b0, v, tag[v], 1'b0);
          end
          s = first_free();
          if (s < 0) begin
            post(KIND_DONE, 1'b0, 0, '0, 1'b1);
          end else begin
            cached[s]   = 1'b1;
            tag[s]      = op.obj_key;
            held_len[s] = BYTES_W'(op.obj_length);
            uses[s]     = USES_W'(1);
            avail = (LEN_W'(avail) >= op.obj_length) ?
                    BYTES_W'(LEN_W'(avail) - op.obj_length) : '0;
            post(KIND_DONE, 1'b1, s, '0, 1'b1);
          end
        end
      end
      REQ_LOOKUP: begin
        s = find_slot(op.obj_key);
        if (s < 0) begin
          post(KIND_DONE, 1'b0, 0, '0, 1'b1);
        end else begin
          if (uses[s] != USES_MAX) uses[s] = uses[s] + USES_W'(1);
          post(KIND_DONE, 1'b1, s, '0, 1'b1);
        end
      end
      REQ_INVAL: begin
        s = find_slot(op.obj_key);
        if (s < 0) begin
          post(KIND_DONE, 1'b0, 0, '0, 1'b1);
        end else begin
          cached[s] = 1'b0;
          give_back(held_len[s]);
          post(KIND_DONE, 1'b1, s, '0, 1'b1);
        end
      end
      default: post(KIND_DONE, 1'b0, 0, '0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_req(logic [TYPE_W-1:0] t, logic [KEY_W-1:0] k, logic [LEN_W-1:0] l);
    cache_op_t op;
    op = '0;
    op.req_type   = t;
    op.obj_key    = k;
    op.obj_length = l;
    op_fifo.push_back(op);
    req_total++;
  endtask

  task automatic push_cap(logic [BYTES_W-1:0] c);
    cache_op_t op;
    op = '0;
    op.is_cap   = 1'b1;
    op.capacity = c;
    op_fifo.push_back(op);
  endtask

  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : driver
    cache_op_t cur;
    logic took;
    logic go_req;
    logic go_cfg;
    if (rst) begin
      req_bus.valid <= 1'b0;
      cfg_bus.valid <= 1'b0;
      burst_left = $urandom_range(1, 8);
      gap_left   = 0;
    end else begin
      took = 1'b0;
      if (req_bus.valid && req_bus.ready) begin
        cur = op_fifo.pop_front();
        lfu_apply(cur);
        sent_cnt++;
        took = 1'b1;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        cur = op_fifo.pop_front();
        set_capacity(cur.capacity);
        took = 1'b1;
      end
      if (took) begin
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
        end
      end
      if (!(req_bus.valid && !req_bus.ready) && !(cfg_bus.valid && !cfg_bus.ready)) begin
        go_req = 1'b0;
        go_cfg = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (op_fifo.size() > 0) begin
          if (!op_fifo[0].is_cap) go_req = 1'b1;
          else if (sent_cnt == done_cnt) go_cfg = 1'b1;
        end
        if (go_req) begin
          req_bus.req_type   <= op_fifo[0].req_type;
          req_bus.obj_key    <= op_fifo[0].obj_key;
          req_bus.obj_length <= op_fifo[0].obj_length;
        end
        if (go_cfg) cfg_bus.capacity_bytes <= op_fifo[0].capacity;
        req_bus.valid <= go_req;
        cfg_bus.valid <= go_cfg;
      end
    end
  end

  int         stall_mode = 0;
  int         mode_left  = 0;
  logic [7:0] ready_pat  = 8'h01;

  always @(posedge clk) begin : monitor
    cache_rsp_t want;
    logic rdy;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      done_cnt      <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (due_rsp.size() == 0) begin
          $error("unexpected result: kind %0d slot %0d", rsp_bus.item_kind,
                 rsp_bus.slot_index);
          mismatches++;
        end else begin
          want = due_rsp.pop_front();
          check_field("item_kind", 32'(want.item_kind), 32'(rsp_bus.item_kind));
          check_field("hit", 32'(want.hit), 32'(rsp_bus.hit));
          check_field("slot_index", 32'(want.slot_index), 32'(rsp_bus.slot_index));
          check_field("evicted_key", want.evicted_key, rsp_bus.evicted_key);
          check_field("free_bytes", 32'(want.free_bytes), 32'(rsp_bus.free_bytes));
          check_field("last", 32'(want.last), 32'(rsp_bus.last));
          if (want.last) done_cnt <= done_cnt + 1;
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(40, 400);
        ready_pat  = 8'($urandom) | 8'h01;
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: begin
          rdy       = ready_pat[0];
          ready_pat = {ready_pat[0], ready_pat[7:1]};
        end
        default: rdy = ($urandom_range(0, 7) == 0);
      endcase
      rsp_bus.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [BYTES_W-1:0] cap_now;
    logic [KEY_W-1:0]   pool [ENTRIES + 8];
    logic [TYPE_W-1:0]  kind;
    logic [KEY_W-1:0]   key;
    logic [LEN_W-1:0]   len;
    int n_rand;
    int phase_len;
    int r;

    rst                    = 1'b1;
    req_bus.valid          = 1'b0;
    req_bus.req_type       = REQ_NONE;
    req_bus.obj_key        = '0;
    req_bus.obj_length     = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.capacity_bytes = '0;
    rsp_bus.ready          = 1'b0;
    set_capacity(CAP_RESET);

    push_req(REQ_LOOKUP, 32'h0, 20'h0);
    push_req(REQ_INVAL, 32'hFFFF_FFFF, 20'h0);
    push_req(REQ_NONE, 32'hFFFF_FFFF, 20'hF_FFFF);
    push_req(REQ_STORE, 32'h1, 20'h1_0000);
    push_req(REQ_STORE, 32'h2, 20'h1);
    push_req(REQ_LOOKUP, 32'h2, 20'h0);
    push_req(REQ_STORE, 32'h2, 20'd100);
    push_req(REQ_STORE, 32'hFFFF_FFFF, 20'h0);
    push_req(REQ_LOOKUP, 32'hFFFF_FFFF, 20'h0);
    push_req(REQ_INVAL, 32'hFFFF_FFFF, 20'h0);
    push_req(REQ_STORE, 32'h3, 20'hF_FFFF);
    push_req(REQ_LOOKUP, 32'h2, 20'h0);
    push_cap(17'd0);
    push_req(REQ_STORE, 32'h5, 20'h0);
    push_req(REQ_STORE, 32'h6, 20'h1);
    push_cap(17'd1);
    push_req(REQ_STORE, 32'h7, 20'h1);
    push_req(REQ_STORE, 32'h8, 20'h1);
    push_req(REQ_STORE, 32'h9, 20'h2);
    push_cap(17'h1_0000);
    push_req(REQ_STORE, 32'hAAAA_AAAA, 20'h1_0000);
    push_req(REQ_STORE, 32'h5555_5555, 20'h0);
    push_req(REQ_INVAL, 32'hAAAA_AAAA, 20'h0);
    push_req(REQ_STORE, 32'h5555_5555, 20'h1_0001);

    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       cap_now = 17'h1_0000;
        1:       cap_now = 17'd0;
        2:       cap_now = 17'd1;
        3:       cap_now = BYTES_W'($urandom_range(0, 65536));
        default: cap_now = BYTES_W'($urandom_range(32, 2048));
      endcase
      push_cap(cap_now);
      foreach (pool[i]) pool[i] = $urandom;

      if (cap_now >= ENTRIES && $urandom_range(0, 2) == 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          push_req(REQ_STORE, pool[i], LEN_W'(cap_now / ENTRIES));
          if ($urandom_range(0, 3) == 0)
            push_req(REQ_LOOKUP, pool[$urandom_range(0, i)], LEN_W'($urandom));
        end
        push_req(REQ_STORE, pool[ENTRIES], LEN_W'(cap_now));
        n_rand += ENTRIES + 1;
      end

      phase_len = $urandom_range(15, 35);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 45)      kind = REQ_STORE;
        else if (r < 80) kind = REQ_LOOKUP;
        else if (r < 95) kind = REQ_INVAL;
        else             kind = REQ_NONE;
        key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, ENTRIES + 7)];
        case ($urandom_range(0, 19))
          0:       len = LEN_W'($urandom_range(0, 20'hF_FFFF));
          1:       len = LEN_W'(cap_now);
          2:       len = LEN_W'(cap_now) + LEN_W'(1);
          3:       len = LEN_W'($urandom_range(0, 3));
          default: len = LEN_W'($urandom_range(0, cap_now / 8 + 1));
        endcase
        push_req(kind, key, len);
        n_rand++;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (done_cnt != req_total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (due_rsp.size() != 0) begin
      $error("%0d expected results never arrived", due_rsp.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
